>>> rtl/core/adb2_pkg.sv
// Shared types and constants for the 2x2 ARGB box downsampler.
package adb2_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_IMAGE_PRESENT = 2'd0;
	localparam logic [1:0] REG_SRC_WIDTH     = 2'd1;
	localparam logic [1:0] REG_SRC_HEIGHT    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [9:0] SRC_WIDTH_RST  = 10'd32;
	localparam logic [9:0] SRC_HEIGHT_RST = 10'd32;

	// Depth of the queue between the front and the back part.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Forced alpha of an averaged pixel.
	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// What the front stage register holds.
	typedef enum logic [1:0] {
		KIND_BLANK = 2'd0,
		KIND_COPY  = 2'd1,
		KIND_AVG   = 2'd2
	} kind_t;

	// One destination pixel on its way to the output.
	typedef struct packed {
		logic [31:0] pixel;
		logic        ok;
	} pkt_t;

	// Per-channel sums of two RGB pixels: red 26..18, green 17..9, blue 8..0.
	function automatic logic [26:0] chan_sum(input logic [23:0] a, input logic [23:0] b);
		logic [8:0] r;
		logic [8:0] g;
		logic [8:0] bl;
		r  = {1'b0, a[23:16]} + {1'b0, b[23:16]};
		g  = {1'b0, a[15:8]} + {1'b0, b[15:8]};
		bl = {1'b0, a[7:0]} + {1'b0, b[7:0]};
		return {r, g, bl};
	endfunction

endpackage

>>> rtl/core/adb2_front.sv
// Front part: configuration registers, pixel intake, mode choice, line store and averaging.
module adb2_front #(
	parameter int OUT_SIDE = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,
	input  logic                      cfg_valid,
	input  logic [1:0]                cfg_index,
	input  logic [9:0]                cfg_data,
	input  logic [adb2_pkg::QCNT_W-1:0] q_count,
	output logic                      push,
	output adb2_pkg::pkt_t            push_data
);

	localparam int SLOT_W = $clog2(OUT_SIDE);
	localparam int POS_W  = SLOT_W + 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 * OUT_SIDE - 1);
	localparam logic [9:0] SIDE_1X = 10'(OUT_SIDE);
	localparam logic [9:0] SIDE_2X = 10'(2 * OUT_SIDE);
	localparam int QCNT_W = adb2_pkg::QCNT_W;

	logic                 image_present_q;
	logic [9:0]           src_width_q;
	logic [9:0]           src_height_q;
	logic [POS_W-1:0]     col_q;
	logic [POS_W-1:0]     row_q;
	logic [23:0]          left_q;
	logic [26:0]          line_mem [OUT_SIDE];

	logic                 valid_s1;
	adb2_pkg::kind_t      kind_s1;
	logic [31:0]          pixel_s1;
	logic [26:0]          top_s1;
	logic [26:0]          low_s1;

	logic                 accept;
	logic                 mode_copy;
	logic                 mode_halve;
	logic [SLOT_W-1:0]    slot;
	logic                 odd_col;
	logic                 bottom;
	logic [26:0]          pair;
	logic [9:0]           sum_r;
	logic [9:0]           sum_g;
	logic [9:0]           sum_b;

	// Room is reserved for the item held in the stage register.
	assign s_tready = ({1'b0, q_count} + (QCNT_W + 1)'(valid_s1)) < (QCNT_W + 1)'(adb2_pkg::QDEPTH);
	assign accept   = s_tvalid && s_tready;

	assign mode_copy  = image_present_q && (src_width_q == SIDE_1X) && (src_height_q == SIDE_1X);
	assign mode_halve = image_present_q && (src_width_q == SIDE_2X) && (src_height_q == SIDE_2X);

	assign slot    = col_q[POS_W-1:1];
	assign odd_col = col_q[0];
	assign bottom  = row_q[0];
	assign pair    = adb2_pkg::chan_sum(left_q, s_tdata[23:0]);

	// Configuration registers take a write whenever one is offered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_present_q <= 1'b0;
			src_width_q     <= adb2_pkg::SRC_WIDTH_RST;
			src_height_q    <= adb2_pkg::SRC_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				adb2_pkg::REG_IMAGE_PRESENT: image_present_q <= cfg_data[0];
				adb2_pkg::REG_SRC_WIDTH:     src_width_q     <= cfg_data;
				adb2_pkg::REG_SRC_HEIGHT:    src_height_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Source position and the left pixel of the current pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!mode_halve) begin
				col_q  <= '0;
				row_q  <= '0;
				left_q <= '0;
			end else begin
				if (!odd_col) begin
					left_q <= s_tdata[23:0];
				end
				if (col_q >= POS_LAST) begin
					col_q <= '0;
					row_q <= (row_q >= POS_LAST) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// Line store of top-row pair sums, one write and one registered read.
	always_ff @(posedge clk) begin
		if (accept && mode_halve && odd_col && !bottom) begin
			line_mem[slot] <= pair;
		end
		if (accept && mode_halve && odd_col && bottom) begin
			top_s1 <= line_mem[slot];
		end
	end

	// Stage register: valid marks an item that makes a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= adb2_pkg::KIND_BLANK;
		end else begin
			valid_s1 <= accept && (!mode_halve || (odd_col && bottom));
			if (accept) begin
				kind_s1 <= mode_halve ? adb2_pkg::KIND_AVG :
					(mode_copy ? adb2_pkg::KIND_COPY : adb2_pkg::KIND_BLANK);
			end
		end
	end

	// Payload of the stage register.
	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= s_tdata;
			low_s1   <= pair;
		end
	end

	// Rounded mean of the four pixels per channel.
	assign sum_r = {1'b0, top_s1[26:18]} + {1'b0, low_s1[26:18]} + 10'd2;
	assign sum_g = {1'b0, top_s1[17:9]} + {1'b0, low_s1[17:9]} + 10'd2;
	assign sum_b = {1'b0, top_s1[8:0]} + {1'b0, low_s1[8:0]} + 10'd2;

	// Build the destination pixel from the stage register.
	always_comb begin
		push = valid_s1;
		unique case (kind_s1)
			adb2_pkg::KIND_COPY: begin
				push_data.pixel = pixel_s1;
				push_data.ok    = 1'b1;
			end
			adb2_pkg::KIND_AVG: begin
				push_data.pixel = {adb2_pkg::ALPHA_OPAQUE, sum_r[9:2], sum_g[9:2], sum_b[9:2]};
				push_data.ok    = 1'b1;
			end
			default: begin
				push_data.pixel = '0;
				push_data.ok    = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/core/adb2_queue.sv
// Short queue of destination pixels between the front and the back part.
module adb2_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  adb2_pkg::pkt_t              push_data,
	input  logic                        pop,
	output adb2_pkg::pkt_t              pop_data,
	output logic                        not_empty,
	output logic [adb2_pkg::QCNT_W-1:0] count
);

	adb2_pkg::pkt_t                  mem_q [adb2_pkg::QDEPTH];
	logic [adb2_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [adb2_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [adb2_pkg::QCNT_W-1:0]     count_q;

	assign count     = count_q;
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/adb2_back.sv
// Back part: frame pixel counter and the output register of the result stream.
module adb2_back #(
	parameter int OUT_SIDE = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           not_empty,
	input  adb2_pkg::pkt_t pop_data,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    m_tdata,
	output logic           m_tuser,
	output logic           m_tlast
);

	localparam int CNT_W = $clog2(OUT_SIDE * OUT_SIDE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_SIDE * OUT_SIDE - 1);

	logic [CNT_W-1:0] out_count_q;
	logic             is_last;

	assign pop     = not_empty && (!m_tvalid || m_tready);
	assign is_last = (out_count_q >= CNT_LAST);

	// Output valid and the destination pixel count of the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid    <= 1'b0;
			out_count_q <= '0;
		end else begin
			if (pop) begin
				m_tvalid    <= 1'b1;
				out_count_q <= is_last ? '0 : out_count_q + 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= pop_data.pixel;
			m_tuser <= pop_data.ok;
			m_tlast <= is_last;
		end
	end

endmodule

>>> rtl/core/argb_box_downsample_2x2_unit.sv
// Top level of the 2x2 ARGB box downsampler.
// Accepts one source pixel per clock while the queue has room and produces OUT_SIDE x
// OUT_SIDE destination pixels. A source of OUT_SIDE square is copied; one of twice that
// side is averaged over 2x2 blocks (alpha forced to 255) with one result on the bottom-right
// pixel of each block; any other size, or image_present at 0, gives a zero pixel with tuser
// low for every input. Sustained rate is one pixel per cycle while the output is not stalled;
// the single-port line store is written on top-row odd pixels and read on bottom-row odd
// pixels. A four-entry queue lets the input keep flowing while the output waits. The line
// store needs no clearing after reset. The user must write configuration only while no
// pixel is in flight; the block itself does not enforce this.
module argb_box_downsample_2x2_unit #(
	parameter int OUT_SIDE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // in_pixel [31:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_pixel [31:0]
	output logic        m_tuser,   // ok [0]
	output logic        m_tlast
);

	logic                        push;
	adb2_pkg::pkt_t              push_data;
	logic                        pop;
	adb2_pkg::pkt_t              pop_data;
	logic                        not_empty;
	logic [adb2_pkg::QCNT_W-1:0] q_count;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	adb2_front #(.OUT_SIDE(OUT_SIDE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	adb2_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty),
		.count     (q_count)
	);

	adb2_back #(.OUT_SIDE(OUT_SIDE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

>>> rtl/core/adb2_checker.sv
// Port-level checker for the 2x2 ARGB box downsampler and its bind statement.
module adb2_checker #(
	parameter int OUT_SIDE = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	localparam int CNT_W = $clog2(OUT_SIDE * OUT_SIDE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_SIDE * OUT_SIDE - 1);

	logic [CNT_W-1:0] seen_q;

	// Count result transfers within the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (m_tvalid && m_tready) begin
			seen_q <= (seen_q == CNT_LAST) ? '0 : seen_q + 1'b1;
		end
	end

	// A stalled result holds still.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// A failing result carries a zero pixel.
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("failing result with nonzero pixel");

	// The frame end falls on the last destination pixel of every frame.
	a_last_place: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> m_tlast == (seen_q == CNT_LAST))
		else $error("frame end marker out of place");

endmodule

bind argb_box_downsample_2x2_unit adb2_checker #(.OUT_SIDE(OUT_SIDE)) u_adb2_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
